/* design/fmqd_pkg.sv */
package fmqd_pkg;

   // Result word width and the divider steps that follow from it
   localparam int OUT_WIDTH   = 16;
   localparam int STEP_W      = $clog2(OUT_WIDTH);
   localparam int MUL_LAST    = 4;

   // Item queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // What the front found out about an item
   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_ZERO   = 2'd1,
      KIND_NORMAL = 2'd2
   } kind_type;

   localparam int KIND_W = 2;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_MUL    = 3'd1,
      ST_CHECK  = 3'd2,
      ST_DIV    = 3'd3,
      ST_FINISH = 3'd4
   } back_state_type;

endpackage

/* design/fmqd_front.sv */
module fmqd_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int REQ_DATA_W   = 32,
   parameter int ENTRY_W      = 4 * 16 + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [ENTRY_W-1:0]    push_data
);

   logic [SAMPLE_WIDTH-1:0] prev_i_ff, prev_i_in;
   logic [SAMPLE_WIDTH-1:0] prev_q_ff, prev_q_in;
   logic                    have_prev_ff, have_prev_in;
   logic [SAMPLE_WIDTH-1:0] i_now;
   logic [SAMPLE_WIDTH-1:0] q_now;
   logic                    accept;
   fmqd_pkg::kind_type      kind;

   assign i_now      = req_tdata[SAMPLE_WIDTH-1:0];
   assign q_now      = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // Classify: first item after reset, zero power, or a real quotient
   always_comb begin
      if (!have_prev_ff) begin
         kind = fmqd_pkg::KIND_FIRST;
      end else if (i_now == '0 && q_now == '0) begin
         kind = fmqd_pkg::KIND_ZERO;
      end else begin
         kind = fmqd_pkg::KIND_NORMAL;
      end
   end

   assign push_data = {kind, prev_q_ff, prev_i_ff, q_now, i_now};

   // Every accepted sample becomes the previous pair
   always_comb begin
      prev_i_in    = prev_i_ff;
      prev_q_in    = prev_q_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         prev_i_in    = i_now;
         prev_q_in    = q_now;
         have_prev_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
      prev_i_ff <= prev_i_in;
      prev_q_ff <= prev_q_in;
   end

endmodule

/* design/fmqd_queue.sv */
module fmqd_queue #(
   parameter int ENTRY_W = 4 * 16 + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  logic [ENTRY_W-1:0] push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output logic [ENTRY_W-1:0] pop_data
);

   logic [ENTRY_W-1:0]          slot_ff [fmqd_pkg::QUEUE_DEPTH];
   logic [fmqd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fmqd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fmqd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != fmqd_pkg::QCNT_W'(fmqd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill count stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fmqd_pkg::QCNT_W'(fmqd_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

/* design/fmqd_back.sv */
module fmqd_back #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int OUT_FRAC_BITS = 14,
   parameter int ENTRY_W       = 4 * 16 + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [ENTRY_W-1:0]            pop_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fmqd_pkg::OUT_WIDTH-1:0] rsp_demod,
   output logic                          rsp_zero_power,
   output logic                          rsp_saturated
);

   localparam int W     = SAMPLE_WIDTH;
   localparam int PW    = 2 * W;
   localparam int NW    = PW + 1;
   localparam int OW    = fmqd_pkg::OUT_WIDTH;
   localparam int DW    = PW + OUT_FRAC_BITS;
   localparam int CW    = PW + ((OUT_FRAC_BITS > OW) ? OUT_FRAC_BITS : OW) + 1;
   localparam int SW    = fmqd_pkg::STEP_W;

   fmqd_pkg::back_state_type state_ff, state_in;
   logic [SW-1:0]            step_ff, step_in;
   logic signed [W-1:0]      i_ff, i_in, q_ff, q_in, ip_ff, ip_in, qp_ff, qp_in;
   fmqd_pkg::kind_type       kind;
   logic signed [W-1:0]      op_a, op_b;
   logic signed [PW-1:0]     mul_prod;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [NW-1:0]     num_ff, num_in;
   logic [PW-1:0]            den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [CW-1:0]            dsh_ff, dsh_in;
   logic [OW-1:0]            quo_ff, quo_in;
   logic [OW-1:0]            res_demod_ff, res_demod_in;
   logic                     res_zp_ff, res_zp_in;
   logic                     res_sat_ff, res_sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]            rsp_demod_ff, rsp_demod_in;
   logic                     rsp_zp_ff, rsp_zp_in;
   logic                     rsp_sat_ff, rsp_sat_in;
   logic signed [NW-1:0]     prod_ext;
   logic [NW-1:0]            mag_full;
   logic [CW-1:0]            dividend;
   logic [CW-1:0]            clip_bound;
   logic                     num_neg;
   logic                     trial_ok;
   logic [OW-1:0]            quo_next;
   logic                     out_free;

   assign kind = fmqd_pkg::kind_type'(pop_data[ENTRY_W-1 -: fmqd_pkg::KIND_W]);

   // Shared multiplier: one product a cycle, registered before use
   always_comb begin
      case (step_ff)
         SW'(0):  begin op_a = q_ff; op_b = ip_ff; end
         SW'(1):  begin op_a = i_ff; op_b = qp_ff; end
         SW'(2):  begin op_a = i_ff; op_b = i_ff;  end
         default: begin op_a = q_ff; op_b = q_ff;  end
      endcase
   end

   assign mul_prod = op_a * op_b;
   assign prod_ext = {prod_ff[PW-1], prod_ff};

   // Magnitude, scaled dividend and clip bound (limit + 1) * den
   assign num_neg    = num_ff[NW-1];
   assign mag_full   = num_neg ? NW'(-num_ff) : NW'(num_ff);
   assign dividend   = CW'({mag_full[PW-1:0], {OUT_FRAC_BITS{1'b0}}});
   assign clip_bound = (CW'(den_ff) << (OW - 1)) + (num_neg ? CW'(den_ff) : CW'(0));

   // One restoring division step
   assign trial_ok = (rem_ff >= dsh_ff);
   assign quo_next = {quo_ff[OW-2:0], trial_ok};

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      q_in         = q_ff;
      ip_in        = ip_ff;
      qp_in        = qp_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      res_demod_in = res_demod_ff;
      res_zp_in    = res_zp_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_demod_in = rsp_demod_ff;
      rsp_zp_in    = rsp_zp_ff;
      rsp_sat_in   = rsp_sat_ff;
      pop_ready    = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         fmqd_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               i_in         = pop_data[W-1:0];
               q_in         = pop_data[2*W-1:W];
               ip_in        = pop_data[3*W-1:2*W];
               qp_in        = pop_data[4*W-1:3*W];
               res_demod_in = '0;
               res_zp_in    = 1'b0;
               res_sat_in   = 1'b0;
               step_in      = '0;
               case (kind)
                  fmqd_pkg::KIND_NORMAL: state_in = fmqd_pkg::ST_MUL;
                  fmqd_pkg::KIND_ZERO: begin
                     res_zp_in = 1'b1;
                     state_in  = fmqd_pkg::ST_FINISH;
                  end
                  default: state_in = fmqd_pkg::ST_FINISH;
               endcase
            end
         end
         fmqd_pkg::ST_MUL: begin
            prod_in = mul_prod;
            step_in = step_ff + 1'b1;
            case (step_ff)
               SW'(1):  num_in = prod_ext;
               SW'(2):  num_in = num_ff - prod_ext;
               SW'(3):  den_in = prod_ff[PW-1:0];
               SW'(4):  den_in = den_ff + prod_ff[PW-1:0];
               default: num_in = num_ff;
            endcase
            if (step_ff == SW'(fmqd_pkg::MUL_LAST)) begin
               state_in = fmqd_pkg::ST_CHECK;
            end
         end
         fmqd_pkg::ST_CHECK: begin
            neg_in = num_neg;
            rem_in = dividend;
            dsh_in = CW'(den_ff) << (OW - 1);
            quo_in = '0;
            step_in = SW'(OW - 1);
            if (den_ff == '0) begin
               res_zp_in = 1'b1;
               state_in  = fmqd_pkg::ST_FINISH;
            end else if (dividend >= clip_bound) begin
               // Clip to the signed output range
               res_sat_in   = 1'b1;
               res_demod_in = num_neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
               state_in     = fmqd_pkg::ST_FINISH;
            end else begin
               state_in = fmqd_pkg::ST_DIV;
            end
         end
         fmqd_pkg::ST_DIV: begin
            if (trial_ok) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in  = dsh_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               res_demod_in = neg_ff ? OW'(-quo_next) : quo_next;
               state_in     = fmqd_pkg::ST_FINISH;
            end
         end
         fmqd_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_demod_in = res_demod_ff;
               rsp_zp_in    = res_zp_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = fmqd_pkg::ST_IDLE;
            end
         end
         default: state_in = fmqd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmqd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      q_ff         <= q_in;
      ip_ff        <= ip_in;
      qp_ff        <= qp_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      res_demod_ff <= res_demod_in;
      res_zp_ff    <= res_zp_in;
      res_sat_ff   <= res_sat_in;
      rsp_demod_ff <= rsp_demod_in;
      rsp_zp_ff    <= rsp_zp_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_demod      = rsp_demod_ff;
   assign rsp_zero_power = rsp_zp_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // A result is never both zero power and clipped
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_zp_ff && rsp_sat_ff))
      else $error("zero power and saturated both set");

   // Zero power forces a zero phase step
   a_zero_power_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zp_ff) |-> (rsp_demod_ff == '0))
      else $error("zero power with nonzero output");

   // Remainder stays below twice the shifted divisor in every step
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmqd_pkg::ST_DIV) |-> ((rem_ff >> 1) < dsh_ff))
      else $error("divider remainder out of range");

endmodule

/* design/fm_quadrature_discriminator_core.sv */
// FM quadrature discriminator. Each req item carries one baseband I/Q pair
// (two's complement, SAMPLE_WIDTH bits each); each rsp item carries the phase
// step (Q*Iprev - I*Qprev) / (I*I + Q*Q), scaled so that 2^OUT_FRAC_BITS is
// 1.0, truncated toward zero and clipped to signed 16 bits, with flags for
// clipping and for a zero-power sample (output 0). The first item after reset
// gives 0 with both flags clear. In the back end an item goes through these
// steps in order: a fetch from the queue, the shared multiplier that forms the
// numerator and the power, the clip check, the restoring divider (one quotient
// bit per cycle) and the load of the output register, which waits while a
// result is still untaken. First-sample and zero-power items skip the arithmetic.
// A two-entry queue and the output register let the input side accept items
// while a result waits to be taken.
module fm_quadrature_discriminator_core #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // i_sample, q_sample
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // demod_out
   output logic [fmqd_pkg::OUT_WIDTH-1:0]            rsp_tdata,
   // zero_power, saturated
   output logic [1:0]                                rsp_tuser
);

   localparam int REQ_DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int ENTRY_W    = 4 * SAMPLE_WIDTH + fmqd_pkg::KIND_W;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   fmqd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .REQ_DATA_W   (REQ_DATA_W),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fmqd_queue #(
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fmqd_back #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_demod      (rsp_tdata),
      .rsp_zero_power (rsp_tuser[0]),
      .rsp_saturated  (rsp_tuser[1])
   );

endmodule

/* test/tb_fm_quadrature_discriminator_core.sv */
module tb_fm_quadrature_discriminator_core;

   localparam int SAMPLE_W      = 16;
   localparam int FRAC_BITS     = 14;
   localparam int RANDOM_ITEMS  = 150;
   localparam int DRAIN_CYCLES  = 40;
   localparam int DIRECTED_ROWS = 25;

   // One phase-step result as it leaves the block
   typedef struct {
      logic signed [15:0] demod;
      logic               zero_power;
      logic               saturated;
   } phase_step_type;

   // One row of the directed table; known rows carry a hand-worked result
   typedef struct {
      logic signed [15:0] i_val;
      logic signed [15:0] q_val;
      bit                 known;
      logic signed [15:0] demod;
      logic               zero_power;
      logic               saturated;
   } directed_row_type;

   logic                                      clock;
   logic                                      reset;
   logic                                      req_tvalid;
   logic                                      req_tready;
   logic [((2*SAMPLE_W+7)/8)*8-1:0]           req_tdata;   // i_sample, q_sample
   logic                                      rsp_tvalid;
   logic                                      rsp_tready;
   logic [fmqd_pkg::OUT_WIDTH-1:0]            rsp_tdata;   // demod_out
   logic [1:0]                                rsp_tuser;   // zero_power, saturated

   // Model state of the discriminator
   logic signed [15:0] last_in_phase;
   logic signed [15:0] last_quadrature;
   bit                 seen_sample;

   phase_step_type     pending_steps[$];
   int                 error_count = 0;
   int                 tx_idle_pct;
   int                 rx_idle_pct;

   // Rotating phasor used for well-formed sample runs
   int                 phasor_i;
   int                 phasor_q;

   directed_row_type   directed_rows[DIRECTED_ROWS] = '{
      '{16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b0, 1'b0}, // first after reset
      '{16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b1, 1'b0}, // zero power
      '{-16'sd32768, -16'sd32768, 1'b1, 16'sd0,      1'b0, 1'b0}, // prior pair zero
      '{16'sd0,      16'sd1,      1'b1, -16'sd32768, 1'b0, 1'b1}, // clip low
      '{16'sd1,      16'sd0,      1'b1, -16'sd16384, 1'b0, 1'b0},
      '{16'sd0,      16'sd1,      1'b1, 16'sd16384,  1'b0, 1'b0},
      '{16'sd32767,  16'sd32767,  1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd0,      -16'sd32768, 1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b1, 1'b0}, // zero power
      '{16'sd32767,  16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd0,      16'sd32767,  1'b1, 16'sd16384,  1'b0, 1'b0},
      '{-16'sd1,     16'sd0,      1'b1, 16'sd32767,  1'b0, 1'b1}, // clip high
      '{16'sd0,      16'sd2,      1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd1,      16'sd0,      1'b1, -16'sd32768, 1'b0, 1'b0}, // exact low bound
      '{16'sd0,      16'sd1,      1'b1, 16'sd16384,  1'b0, 1'b0},
      '{16'sd2,      16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd0,      16'sd1,      1'b1, 16'sd32767,  1'b0, 1'b1}, // just over high bound
      '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0,      1'b0, 1'b0},
      '{-16'sd1,     -16'sd1,     1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b1, 1'b0}, // zero power
      '{-16'sd32768, 16'sd0,      1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd5,      -16'sd3,     1'b0, 16'sd0,      1'b0, 1'b0},
      '{16'sd3,      16'sd7,      1'b0, 16'sd0,      1'b0, 1'b0}, // truncation
      '{-16'sd7,     16'sd3,      1'b0, 16'sd0,      1'b0, 1'b0}
   };

   fm_quadrature_discriminator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Phase step of the new pair against the stored one; advance the stored pair
   function automatic phase_step_type predict_phase_step(input logic signed [15:0] i_now,
                                                         input logic signed [15:0] q_now);
      longint         cross_term;
      longint         power;
      longint         magnitude;
      longint         quotient;
      longint         bound;
      phase_step_type step;
      step.demod      = '0;
      step.zero_power = 1'b0;
      step.saturated  = 1'b0;
      if (seen_sample) begin
         cross_term = longint'(q_now) * longint'(last_in_phase)
                    - longint'(i_now) * longint'(last_quadrature);
         power = longint'(i_now) * longint'(i_now) + longint'(q_now) * longint'(q_now);
         if (power == 0) begin
            step.zero_power = 1'b1;
         end else begin
            magnitude = (cross_term < 0) ? -cross_term : cross_term;
            bound     = (cross_term < 0) ? 64'sd32768 : 64'sd32767;
            quotient  = (magnitude <<< FRAC_BITS) / power;
            if (quotient > bound) begin
               quotient       = bound;
               step.saturated = 1'b1;
            end
            step.demod = (cross_term < 0) ? 16'(-quotient) : 16'(quotient);
         end
      end
      last_in_phase   = i_now;
      last_quadrature = q_now;
      seen_sample     = 1'b1;
      return step;
   endfunction

   // Offer one I/Q item at a falling edge and hold it until accepted
   task automatic send_sample(input logic signed [15:0] i_val,
                              input logic signed [15:0] q_val,
                              input bit known, input phase_step_type known_step);
      phase_step_type step;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q_val, i_val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step = predict_phase_step(i_val, q_val);
      if (known) begin
         step = known_step;
      end
      pending_steps.insert(pending_steps.size(), step);
      @(negedge clock);
   endtask

   task automatic send_predicted(input logic signed [15:0] i_val,
                                 input logic signed [15:0] q_val);
      phase_step_type unused;
      unused = '{16'sd0, 1'b0, 1'b0};
      send_sample(i_val, q_val, 1'b0, unused);
   endtask

   // Drop valid and hold off until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_steps.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_edge_value();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return -16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // Mostly runs of a slowly rotating phasor, with noise, tiny values and edges
   task automatic run_random_items(input int count);
      int sent;
      int run_len;
      int shift;
      int spin;
      int next_i;
      int next_q;
      int mode;
      sent = 0;
      while (sent < count) begin
         mode = $urandom_range(0, 99);
         if (mode < 55) begin
            run_len  = $urandom_range(5, 20);
            shift    = $urandom_range(1, 7);
            spin     = $urandom_range(0, 1) ? 1 : -1;
            phasor_i = $urandom_range(0, 32000) - 16000;
            phasor_q = $urandom_range(0, 32000) - 16000;
            for (int k = 0; k < run_len && sent < count; k++) begin
               next_i = phasor_i - spin * (phasor_q >>> shift);
               next_q = phasor_q + spin * (phasor_i >>> shift);
               // keep the amplitude in range as the rotation grows it
               if (next_i > 16000 || next_i < -16000 || next_q > 16000 || next_q < -16000) begin
                  next_i = next_i >>> 1;
                  next_q = next_q >>> 1;
               end
               phasor_i = next_i;
               phasor_q = next_q;
               send_predicted(16'(phasor_i), 16'(phasor_q));
               sent++;
            end
         end else if (mode < 75) begin
            send_predicted(16'($urandom()), 16'($urandom()));
            sent++;
         end else if (mode < 88) begin
            send_predicted(16'($urandom_range(0, 6) - 3), 16'($urandom_range(0, 6) - 3));
            sent++;
         end else if (mode < 93) begin
            send_predicted(16'sd0, 16'sd0);
            sent++;
         end else begin
            send_predicted(pick_edge_value(), pick_edge_value());
            sent++;
         end
      end
   endtask

   // Receiver readiness changes at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      phase_step_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_steps.size() == 0) begin
            $error("unexpected result item: demod_out %0d", $signed(rsp_tdata));
            error_count++;
         end else begin
            want = pending_steps.pop_front();
            if ($signed(rsp_tdata) !== want.demod) begin
               $error("demod_out: expected %0d, got %0d", want.demod, $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser[0] !== want.zero_power) begin
               $error("zero_power: expected %0b, got %0b", want.zero_power, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("fm_quadrature_discriminator_core regression: fail");
      $finish;
   end

   initial begin
      phase_step_type row_step;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      last_in_phase   = '0;
      last_quadrature = '0;
      seen_sample     = 1'b0;
      tx_idle_pct     = 21;
      rx_idle_pct     = 81;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (directed_rows[n]) begin
         row_step.demod      = directed_rows[n].demod;
         row_step.zero_power = directed_rows[n].zero_power;
         row_step.saturated  = directed_rows[n].saturated;
         send_sample(directed_rows[n].i_val, directed_rows[n].q_val,
                     directed_rows[n].known, row_step);
      end
      run_random_items(RANDOM_ITEMS);

      // Slow sender, fast receiver; hold off once until the block drains
      tx_idle_pct = 81;
      rx_idle_pct = 21;
      run_random_items(RANDOM_ITEMS / 2);
      wait_drained();
      @(negedge clock);
      run_random_items(RANDOM_ITEMS - RANDOM_ITEMS / 2);

      // Both sides at full rate
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random_items(RANDOM_ITEMS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_steps.size() == 0) begin
         $display("fm_quadrature_discriminator_core regression: pass");
      end else begin
         $display("fm_quadrature_discriminator_core regression: fail");
      end
      $finish;
   end

endmodule
